// ===== rtl/sll_pkg.sv =====
// ----------------------------------------------------------------------------
// sll_pkg
// Shared types, codes and constants of the distinct-count estimator.
// ----------------------------------------------------------------------------
package sll_pkg;

   localparam int MAX_INDEX_BITS_DEF = 12;
   localparam int RANK_WIDTH_DEF     = 64;
   localparam int ENTRY_IDX_W        = 16;
   localparam int VAL_W              = 7;
   localparam int HIST_DEPTH         = 128;
   localparam int HIST_AW            = 7;
   localparam int DVS_W              = 17;
   localparam int POW_STEPS          = 16;
   localparam int FRAC_W             = 16;
   localparam int P_W                = 31;
   localparam int EST_W              = 31;
   localparam int IP_W               = 7;
   localparam int X_W                = IP_W + FRAC_W;

   localparam logic [15:0]      EST_SCALE = 16'd39701;
   localparam logic [DVS_W-1:0] EST_DIV   = 17'd100000;
   // 100000 = 32 * 3125: drop five bits, then multiply by ceil(2^39 / 3125)
   localparam int               EST_PRESHIFT = 5;
   localparam int               EST_RECIP_W  = 28;
   localparam logic [27:0]      EST_RECIP    = 28'd175921861;
   localparam int               EST_RECIP_SH = 39;
   localparam int               QDIG_W       = 15;
   localparam logic [3:0]       INDEX_BITS_RST = 4'd10;
   localparam logic [6:0]       LIMIT_RST      = 7'd23;
   localparam logic             CSR_INDEX_BITS = 1'b0;
   localparam logic             CSR_LIMIT      = 1'b1;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_MERGE,
      OP_CLEAR,
      OP_ESTIMATE
   } sll_op_type;

   typedef struct packed {
      sll_op_type               op;
      logic [ENTRY_IDX_W-1:0]   idx;
      logic [VAL_W-1:0]         val;
      logic                     skip;
   } sll_entry_type;

   typedef enum logic [4:0] {
      ST_INIT, ST_IDLE, ST_RD, ST_UPD, ST_CLR,
      ST_H0, ST_H1, ST_H2, ST_W0, ST_W1,
      ST_D1, ST_D1W, ST_PM, ST_PS, ST_SC, ST_TM, ST_D2, ST_QM, ST_QS, ST_D2W
   } sll_state_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bit_v;
      v = v_in;
      res = '0;
      bit_v = 64'h1 << 62;
      while (bit_v > v) bit_v = bit_v >> 2;
      while (bit_v != 64'd0) begin
         if (v >= res + bit_v) begin
            v = v - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // q30 value of 2^(2^-k), by repeated square roots of 2.0
   function automatic logic [P_W-1:0] pow_coef(input int k);
      logic [63:0] c;
      c = 64'd2 << 30;
      for (int j = 1; j <= k; j++) c = isqrt64(c << 30);
      return c[P_W-1:0];
   endfunction

endpackage

// ===== rtl/superloglog_distinct_counter_unit.sv =====
// ----------------------------------------------------------------------------
// superloglog_distinct_counter_unit
// Distinct-count estimator with rank registers in RAM and a two-deep queue.
// ----------------------------------------------------------------------------
// Every command gives exactly one result strobe, which the receiver cannot
// stall. Commands wait in a two-entry queue; busy rises when it is full and,
// after reset, during the sweep over all 2^MAX_INDEX_BITS entries that zeroes
// the rank RAM. Add and merge go through dequeue, RAM read, and compare and
// write. Clear zeroes all 2^MAX_INDEX_BITS RAM entries, one RAM entry a cycle.
// Estimate makes a histogram pass over the registers, with m = 2^index_bits,
// a pass over the 128 bins, one pass of the bit-serial divider for sum/m0,
// the fractional power steps and a division by 100000 in four 15-bit digits
// through a reciprocal multiply.
module superloglog_distinct_counter_unit #(
   parameter int MAX_INDEX_BITS = sll_pkg::MAX_INDEX_BITS_DEF,
   parameter int RANK_WIDTH     = sll_pkg::RANK_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_hash_prefix,
   input  logic [63:0] req_rank_field,
   input  logic [11:0] req_merge_index,
   input  logic [6:0]  req_merge_value,
   output logic        rsp_strobe,
   output logic        rsp_estimate_valid,
   output logic [30:0] rsp_estimate,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [6:0]  csr_wdata
);
   import sll_pkg::*;

   localparam int BITS_W = $clog2(MAX_INDEX_BITS + 1);

   logic [3:0]        index_bits_ff;
   logic [6:0]        limit_ff;
   logic [BITS_W-1:0] eff_bits;
   logic              init_busy;
   logic              q_valid, q_pop;
   sll_entry_type     q_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         index_bits_ff <= INDEX_BITS_RST;
         limit_ff      <= LIMIT_RST;
      end else if (csr_we) begin
         if (csr_index == CSR_INDEX_BITS) index_bits_ff <= csr_wdata[3:0];
         if (csr_index == CSR_LIMIT)      limit_ff      <= csr_wdata;
      end
   end

   always_comb begin
      if (index_bits_ff < 4'd4)
         eff_bits = BITS_W'(4);
      else if (32'(index_bits_ff) > MAX_INDEX_BITS)
         eff_bits = BITS_W'(MAX_INDEX_BITS);
      else
         eff_bits = BITS_W'(index_bits_ff);
   end

   sll_front #(.MAX_INDEX_BITS(MAX_INDEX_BITS), .RANK_WIDTH(RANK_WIDTH)) u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_hash_prefix(req_hash_prefix),
      .req_rank_field(req_rank_field), .req_merge_index(req_merge_index),
      .req_merge_value(req_merge_value), .eff_bits(eff_bits),
      .init_busy(init_busy), .q_valid(q_valid), .q_entry(q_entry), .q_pop(q_pop)
   );

   sll_back #(.MAX_INDEX_BITS(MAX_INDEX_BITS)) u_back (
      .clock(clock), .reset(reset), .eff_bits(eff_bits), .limit(limit_ff),
      .q_valid(q_valid), .q_entry(q_entry), .q_pop(q_pop), .init_busy(init_busy),
      .rsp_strobe(rsp_strobe), .rsp_estimate_valid(rsp_estimate_valid),
      .rsp_estimate(rsp_estimate)
   );
endmodule

// ===== rtl/sll_ram.sv =====
// ----------------------------------------------------------------------------
// sll_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sll_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/sll_front.sv =====
// ----------------------------------------------------------------------------
// sll_front
// Accepts commands, derives register index and rank, and queues them.
// ----------------------------------------------------------------------------
module sll_front #(
   parameter int MAX_INDEX_BITS = sll_pkg::MAX_INDEX_BITS_DEF,
   parameter int RANK_WIDTH     = sll_pkg::RANK_WIDTH_DEF,
   parameter int BITS_W         = $clog2(MAX_INDEX_BITS + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_op,
   input  logic [31:0]            req_hash_prefix,
   input  logic [63:0]            req_rank_field,
   input  logic [11:0]            req_merge_index,
   input  logic [6:0]             req_merge_value,
   input  logic [BITS_W-1:0]      eff_bits,
   input  logic                   init_busy,
   output logic                   q_valid,
   output sll_pkg::sll_entry_type q_entry,
   input  logic                   q_pop
);
   import sll_pkg::*;

   sll_entry_type ent_ff [2];
   sll_entry_type ent_new;
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic          push;
   logic [VAL_W-1:0] rank;
   logic [MAX_INDEX_BITS:0] m;
   logic [31:0]   hidx;

   always_comb begin
      rank = VAL_W'(RANK_WIDTH + 1);
      for (int b = RANK_WIDTH - 1; b >= 0; b--) begin
         if (req_rank_field[b]) rank = VAL_W'(b + 1);
      end
   end

   assign m    = (MAX_INDEX_BITS + 1)'(1) << eff_bits;
   assign hidx = req_hash_prefix >> (6'd32 - 6'(eff_bits));

   always_comb begin
      ent_new      = '0;
      ent_new.op   = sll_op_type'(req_op);
      case (sll_op_type'(req_op))
         OP_ADD: begin
            ent_new.idx = ENTRY_IDX_W'(hidx[MAX_INDEX_BITS-1:0]);
            ent_new.val = rank;
         end
         OP_MERGE: begin
            ent_new.idx  = ENTRY_IDX_W'(req_merge_index);
            ent_new.val  = req_merge_value;
            ent_new.skip = (32'(req_merge_index) >= 32'(m));
         end
         default: ;
      endcase
   end

   assign busy    = (cnt_ff == 2'd2) | init_busy;
   assign push    = start & ~busy;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_entry = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      cnt_in    = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (push) ent_ff[wr_ptr_ff] <= ent_new;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end
endmodule

// ===== rtl/sll_div.sv =====
// ----------------------------------------------------------------------------
// sll_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sll_div #(
   parameter int DIV_W = 59
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      div_start,
   input  logic [DIV_W-1:0]          dividend,
   input  logic [sll_pkg::DVS_W-1:0] divisor,
   output logic                      div_done,
   output logic [DIV_W-1:0]          quotient
);
   import sll_pkg::*;

   localparam int CTR_W = $clog2(DIV_W + 1);

   logic             busy_ff, busy_in;
   logic [CTR_W-1:0] ctr_ff, ctr_in;
   logic [DIV_W-1:0] qr_ff, qr_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   trial;
   logic             ge;

   assign trial = {rem_ff, qr_ff[DIV_W-1]};
   assign ge    = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      ctr_in  = ctr_ff;
      qr_in   = qr_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      done_in = 1'b0;
      if (div_start) begin
         busy_in = 1'b1;
         ctr_in  = '0;
         qr_in   = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? DVS_W'(trial - {1'b0, dvs_ff}) : trial[DVS_W-1:0];
         qr_in  = {qr_ff[DIV_W-2:0], ge};
         ctr_in = ctr_ff + 1'b1;
         if (ctr_ff == CTR_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      qr_ff  <= qr_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      ctr_ff <= ctr_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_done = done_ff;
   assign quotient = qr_ff;
endmodule

// ===== rtl/sll_back.sv =====
// ----------------------------------------------------------------------------
// sll_back
// Command sequencer: register updates, clear sweep and the estimate.
// ----------------------------------------------------------------------------
module sll_back #(
   parameter int MAX_INDEX_BITS = sll_pkg::MAX_INDEX_BITS_DEF,
   parameter int BITS_W         = $clog2(MAX_INDEX_BITS + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [BITS_W-1:0]      eff_bits,
   input  logic [6:0]             limit,
   input  logic                   q_valid,
   input  sll_pkg::sll_entry_type q_entry,
   output logic                   q_pop,
   output logic                   init_busy,
   output logic                   rsp_strobe,
   output logic                   rsp_estimate_valid,
   output logic [30:0]            rsp_estimate
);
   import sll_pkg::*;

   localparam int DEPTH   = 1 << MAX_INDEX_BITS;
   localparam int AW      = MAX_INDEX_BITS;
   localparam int CNT_W   = MAX_INDEX_BITS + 1;
   localparam int SUM_W   = MAX_INDEX_BITS + VAL_W;
   localparam int SCALE_W = MAX_INDEX_BITS + 16;
   localparam int TPROD_W = SCALE_W + P_W;
   localparam int DIV_W   = SUM_W + FRAC_W;
   localparam int NDIG    = (TPROD_W + QDIG_W - 1) / QDIG_W;
   localparam int QW      = NDIG * QDIG_W;
   localparam int DIG_W   = $clog2(NDIG);
   localparam int QY_W    = DVS_W + QDIG_W;
   localparam int QPROD_W = QY_W - EST_PRESHIFT + EST_RECIP_W;

   sll_state_type state_ff, state_in;
   sll_entry_type cur_ff, cur_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [7:0]         v_ff, v_in;
   logic [VAL_W-1:0]   val_ff, val_in;
   logic [CNT_W-1:0]   left_ff, left_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [X_W-1:0]     x_ff, x_in;
   logic [3:0]         k_ff, k_in;
   logic [P_W-1:0]     p_ff, p_in;
   logic [2*P_W-1:0]   prod_ff, prod_in;
   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic [TPROD_W-1:0] tprod_ff, tprod_in;
   logic [QW-1:0]      num_ff, num_in;
   logic [QW-1:0]      quo_ff, quo_in;
   logic [DVS_W-1:0]   rq_ff, rq_in;
   logic [QY_W-1:0]    y_ff, y_in;
   logic [QPROD_W-1:0] qprod_ff, qprod_in;
   logic [DIG_W-1:0]   dig_ff, dig_in;
   logic [HIST_DEPTH-1:0] hvld_ff, hvld_in;
   logic               str_ff, str_in;
   logic               ev_ff, ev_in;
   logic [EST_W-1:0]   est_ff, est_in;

   logic               rk_we;
   logic [AW-1:0]      rk_waddr, rk_raddr;
   logic [VAL_W-1:0]   rk_wdata, rk_rdata;
   logic               hs_we;
   logic [HIST_AW-1:0] hs_waddr, hs_raddr;
   logic [CNT_W-1:0]   hs_wdata, hs_rdata;
   logic               div_start, div_done;
   logic [DIV_W-1:0]   dividend, quotient;
   logic [DVS_W-1:0]   divisor;

   logic [P_W-1:0]     coef [POW_STEPS];
   logic [AW-1:0]      m0_tab [MAX_INDEX_BITS+1];
   logic [AW-1:0]      m0;
   logic [CNT_W-1:0]   m;
   logic [CNT_W-1:0]   hcnt, take;
   logic [IP_W-1:0]    ip;
   logic [QW-1:0]      shifted;
   logic [QY_W-1:0]    qy;
   logic [QDIG_W-1:0]  qd;

   for (genvar g = 0; g < POW_STEPS; g++) begin : g_coef
      localparam logic [P_W-1:0] CK = pow_coef(g + 1);
      assign coef[g] = CK;
   end

   for (genvar g = 0; g <= MAX_INDEX_BITS; g++) begin : g_m0
      localparam int M0 = (7 * (1 << g)) / 10;
      assign m0_tab[g] = AW'(M0);
   end

   assign m0 = m0_tab[eff_bits];
   assign m  = CNT_W'(1) << eff_bits;
   assign ip = x_ff[X_W-1:FRAC_W];
   assign shifted = quo_ff >> (6'd30 - 6'(ip[4:0]));
   // one decimal-free digit step: partial remainder joined with the next digit
   assign qy = {rq_ff, num_ff[QW-1 -: QDIG_W]};
   assign qd = qprod_ff[EST_RECIP_SH +: QDIG_W];

   sll_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_rank_ram (
      .clock(clock), .we(rk_we), .waddr(rk_waddr), .wdata(rk_wdata),
      .raddr(rk_raddr), .rdata(rk_rdata)
   );

   sll_ram #(.WIDTH(CNT_W), .DEPTH(HIST_DEPTH)) u_hist_ram (
      .clock(clock), .we(hs_we), .waddr(hs_waddr), .wdata(hs_wdata),
      .raddr(hs_raddr), .rdata(hs_rdata)
   );

   sll_div #(.DIV_W(DIV_W)) u_div (
      .clock(clock), .reset(reset), .div_start(div_start), .dividend(dividend),
      .divisor(divisor), .div_done(div_done), .quotient(quotient)
   );

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      cnt_in   = cnt_ff;
      v_in     = v_ff;
      val_in   = val_ff;
      left_in  = left_ff;
      sum_in   = sum_ff;
      x_in     = x_ff;
      k_in     = k_ff;
      p_in     = p_ff;
      prod_in  = prod_ff;
      scale_in = scale_ff;
      tprod_in = tprod_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;
      rq_in    = rq_ff;
      y_in     = y_ff;
      qprod_in = qprod_ff;
      dig_in   = dig_ff;
      hvld_in  = hvld_ff;
      str_in   = 1'b0;
      ev_in    = 1'b0;
      est_in   = '0;
      q_pop    = 1'b0;
      rk_we    = 1'b0;
      rk_waddr = cnt_ff[AW-1:0];
      rk_wdata = '0;
      rk_raddr = cnt_ff[AW-1:0];
      hs_we    = 1'b0;
      hs_waddr = val_ff;
      hs_wdata = '0;
      hs_raddr = v_ff[HIST_AW-1:0];
      div_start = 1'b0;
      dividend  = DIV_W'({sum_ff, {FRAC_W{1'b0}}});
      divisor   = DVS_W'(m0);
      hcnt = hvld_ff[val_ff] ? hs_rdata : '0;
      take = '0;

      case (state_ff)
         ST_INIT: begin
            rk_we  = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DEPTH - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cur_in = q_entry;
               cnt_in = '0;
               case (q_entry.op)
                  OP_ADD, OP_MERGE: state_in = ST_RD;
                  OP_CLEAR:         state_in = ST_CLR;
                  default: begin
                     hvld_in  = '0;
                     state_in = ST_H0;
                  end
               endcase
            end
         end
         ST_RD: begin
            rk_raddr = cur_ff.idx[AW-1:0];
            state_in = ST_UPD;
         end
         ST_UPD: begin
            rk_waddr = cur_ff.idx[AW-1:0];
            rk_wdata = cur_ff.val;
            rk_we    = ~cur_ff.skip & (cur_ff.val > rk_rdata);
            str_in   = 1'b1;
            state_in = ST_IDLE;
         end
         ST_CLR: begin
            rk_we  = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DEPTH - 1)) begin
               str_in   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_H0: state_in = ST_H1;
         ST_H1: begin
            val_in   = rk_rdata;
            hs_raddr = rk_rdata;
            state_in = ST_H2;
         end
         ST_H2: begin
            hs_we    = 1'b1;
            hs_wdata = hcnt + 1'b1;
            hvld_in[val_ff] = 1'b1;
            if (cnt_ff == m - 1'b1) begin
               v_in     = '0;
               left_in  = CNT_W'(m0);
               sum_in   = '0;
               state_in = ST_W0;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_H0;
            end
         end
         ST_W0: state_in = ST_W1;
         ST_W1: begin
            hcnt    = hvld_ff[v_ff[HIST_AW-1:0]] ? hs_rdata : '0;
            take    = (hcnt < left_ff) ? hcnt : left_ff;
            left_in = left_ff - take;
            if (v_ff[HIST_AW-1:0] <= limit)
               sum_in = sum_ff + SUM_W'(v_ff[HIST_AW-1:0]) * SUM_W'(take);
            if (v_ff == 8'(HIST_DEPTH - 1)) begin
               state_in = ST_D1;
            end else begin
               v_in     = v_ff + 1'b1;
               state_in = ST_W0;
            end
         end
         ST_D1: begin
            div_start = 1'b1;
            state_in  = ST_D1W;
         end
         ST_D1W: begin
            if (div_done) begin
               x_in     = quotient[X_W-1:0];
               p_in     = P_W'(1) << 30;
               k_in     = '0;
               state_in = ST_PM;
            end
         end
         ST_PM: begin
            prod_in  = p_ff * coef[k_ff];
            state_in = ST_PS;
         end
         ST_PS: begin
            // step k applies 2^(2^-(k+1)) when that fraction bit is set
            if (x_ff[FRAC_W-1-k_ff]) p_in = prod_ff[30 +: P_W];
            k_in = k_ff + 1'b1;
            state_in = (k_ff == 4'(POW_STEPS - 1)) ? ST_SC : ST_PM;
         end
         ST_SC: begin
            scale_in = SCALE_W'(m0) * SCALE_W'(EST_SCALE);
            state_in = ST_TM;
         end
         ST_TM: begin
            tprod_in = scale_ff * p_ff;
            state_in = ST_D2;
         end
         ST_D2: begin
            num_in   = QW'(tprod_ff);
            rq_in    = '0;
            dig_in   = '0;
            state_in = ST_QM;
         end
         ST_QM: begin
            // quotient digit by reciprocal multiply, exact for qy below 2^32
            y_in     = qy;
            qprod_in = QPROD_W'(qy[QY_W-1:EST_PRESHIFT]) * QPROD_W'(EST_RECIP);
            num_in   = num_ff << QDIG_W;
            state_in = ST_QS;
         end
         ST_QS: begin
            rq_in  = DVS_W'(y_ff - QY_W'(qd) * QY_W'(EST_DIV));
            quo_in = {quo_ff[QW-QDIG_W-1:0], qd};
            dig_in = dig_ff + 1'b1;
            state_in = (dig_ff == DIG_W'(NDIG - 1)) ? ST_D2W : ST_QM;
         end
         ST_D2W: begin
            str_in = 1'b1;
            ev_in  = 1'b1;
            if (ip >= IP_W'(31) || shifted > QW'(32'h7FFF_FFFF))
               est_in = {EST_W{1'b1}};
            else
               est_in = shifted[EST_W-1:0];
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      v_ff     <= v_in;
      val_ff   <= val_in;
      left_ff  <= left_in;
      sum_ff   <= sum_in;
      x_ff     <= x_in;
      k_ff     <= k_in;
      p_ff     <= p_in;
      prod_ff  <= prod_in;
      scale_ff <= scale_in;
      tprod_ff <= tprod_in;
      num_ff   <= num_in;
      quo_ff   <= quo_in;
      rq_ff    <= rq_in;
      y_ff     <= y_in;
      qprod_ff <= qprod_in;
      dig_ff   <= dig_in;
      est_ff   <= est_in;
      ev_ff    <= ev_in;
      if (reset) begin
         state_ff <= ST_INIT;
         cnt_ff   <= '0;
         hvld_ff  <= '0;
         str_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         hvld_ff  <= hvld_in;
         str_ff   <= str_in;
      end
   end

   assign init_busy          = (state_ff == ST_INIT);
   assign rsp_strobe         = str_ff;
   assign rsp_estimate_valid = str_ff & ev_ff;
   assign rsp_estimate       = str_ff ? est_ff : '0;
endmodule

// ===== rtl/sll_checker.sv =====
// ----------------------------------------------------------------------------
// sll_checker
// Port-level checks of the estimator, bound to the top level.
// ----------------------------------------------------------------------------
module sll_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_op,
   input logic [31:0] req_hash_prefix,
   input logic [63:0] req_rank_field,
   input logic [11:0] req_merge_index,
   input logic [6:0]  req_merge_value,
   input logic        rsp_strobe,
   input logic        rsp_estimate_valid,
   input logic [30:0] rsp_estimate,
   input logic        csr_we,
   input logic        csr_index,
   input logic [6:0]  csr_wdata
);
   // no transaction may be accepted while the ram sweep after reset runs
   a_busy_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> busy) else $error("busy low after reset");

   a_quiet_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_strobe |-> (rsp_estimate == 31'd0) && !rsp_estimate_valid)
      else $error("result fields active without strobe");

   a_non_estimate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_estimate_valid |-> rsp_estimate == 31'd0)
      else $error("non-estimate result carries a value");

   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("back-to-back result strobes");
endmodule

bind superloglog_distinct_counter_unit sll_checker u_sll_checker (.*);
